/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clock, held off in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_NOW(label, ante, cons, msg)

`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* sv/snli_pkg.sv */
// ---------------------------------------------------------------------------
// snli_pkg
// types and constants of the sorted node list
// ---------------------------------------------------------------------------
package snli_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int RANK_W      = 8;
   localparam int ID_W        = 8;
   localparam int DIST_W      = 10;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   new_node_id;
      logic [DIST_W-1:0] new_distance;
      logic [ID_W-1:0]   new_back_node;
      logic              new_explorable;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [RANK_W-1:0] rank;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   node_id;
      logic [DIST_W-1:0] distance;
      logic [ID_W-1:0]   back_node;
      logic              explorable;
   } slot_type;

   typedef struct packed {
      logic             active;
      logic             dup;
      logic [CNT_W-1:0] cnt;
   } token_type;

   localparam slot_type START_SLOT = '{
      valid: 1'b1, node_id: ID_W'(1), distance: '0, back_node: ID_W'(1), explorable: 1'b0};

   localparam slot_type EMPTY_SLOT = '0;

endpackage

/* sv/sorted_node_list_insert.sv */
// ---------------------------------------------------------------------------
// sorted_node_list_insert
// Keeps TABLE_DEPTH node records sorted by ascending distance in a chain of
// slot cells; slot 0 holds the start node after reset. Each item gets one
// result: inserted with its slot, duplicate id, or table full. A probe token
// walks the cell chain one slot per cycle, gathering the duplicate flag and
// the insert position; once the output register is free, an inserted item
// is committed, shifting and loading the cells. No new item is taken until
// the result is written to the output register, where it waits; the next
// item can then be taken, but cannot finish until that register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_node_list_insert (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  snli_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output snli_pkg::rsp_type rsp_data
);
   import snli_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic             launch_ff, launch_in;
   logic             dup_ff, dup_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   slot_type  slots [TABLE_DEPTH];
   logic      greater [TABLE_DEPTH];
   token_type toks [TABLE_DEPTH];
   token_type launch_tok;

   logic req_accept, out_free, commit, full;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign full       = slots[TABLE_DEPTH-1].valid;
   assign commit     = (state_ff == ST_DONE) && out_free && !dup_ff && !full;

   always_comb begin
      launch_tok.active = launch_ff;
      launch_tok.dup    = 1'b0;
      launch_tok.cnt    = '0;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         snli_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .rst_slot     (START_SLOT),
            .item         (item_ff),
            .commit       (commit),
            .prev_slot    (EMPTY_SLOT),
            .prev_greater (1'b0),
            .tok_in       (launch_tok),
            .slot_out     (slots[i]),
            .greater      (greater[i]),
            .tok_out      (toks[i])
         );
      end else begin : g_body
         snli_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .rst_slot     (EMPTY_SLOT),
            .item         (item_ff),
            .commit       (commit),
            .prev_slot    (slots[i-1]),
            .prev_greater (greater[i-1]),
            .tok_in       (toks[i-1]),
            .slot_out     (slots[i]),
            .greater      (greater[i]),
            .tok_out      (toks[i])
         );
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      launch_in    = 1'b0;
      dup_in       = dup_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in   = req_data;
               launch_in = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (toks[TABLE_DEPTH-1].active) begin
               dup_in   = toks[TABLE_DEPTH-1].dup;
               cnt_in   = toks[TABLE_DEPTH-1].cnt;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (dup_ff) begin
                  rsp_data_in.status = ST_DUPLICATE;
                  rsp_data_in.rank   = '0;
               end else if (full) begin
                  rsp_data_in.status = ST_FULL;
                  rsp_data_in.rank   = '0;
               end else begin
                  rsp_data_in.status = ST_INSERTED;
                  rsp_data_in.rank   = RANK_W'(cnt_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      dup_ff      <= dup_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_accept_scan, req_accept, state_ff == ST_SCAN && launch_ff, "accept without scan launch")
   `ASSERT_NOW(a_head_valid, 1'b1, slots[0].valid, "start node slot lost")
   `ASSERT_NOW(a_token_in_scan, toks[TABLE_DEPTH-1].active, state_ff == ST_SCAN, "probe token outside scan")
   `ASSERT_NOW(a_reject_rank, rsp_valid && rsp_data.status != ST_INSERTED, rsp_data.rank == '0, "rejected item with rank")

endmodule

/* sv/snli_cell.sv */
// ---------------------------------------------------------------------------
// snli_cell
// one table slot: compares against the item, passes the probe token on and
// shifts or loads on commit
// ---------------------------------------------------------------------------
module snli_cell (
   input  logic               clock,
   input  logic               reset,
   input  snli_pkg::slot_type  rst_slot,
   input  snli_pkg::req_type   item,
   input  logic               commit,
   input  snli_pkg::slot_type  prev_slot,
   input  logic               prev_greater,
   input  snli_pkg::token_type tok_in,
   output snli_pkg::slot_type  slot_out,
   output logic               greater,
   output snli_pkg::token_type tok_out
);
   import snli_pkg::*;

   slot_type  slot_ff, slot_in;
   token_type tok_ff, tok_in_nxt;
   logic      match;

   assign greater = !slot_ff.valid || (slot_ff.distance > item.new_distance);
   assign match   = slot_ff.valid && (slot_ff.node_id == item.new_node_id);

   always_comb begin
      tok_in_nxt.active = tok_in.active;
      tok_in_nxt.dup    = tok_in.dup | match;
      tok_in_nxt.cnt    = tok_in.cnt + {{(CNT_W-1){1'b0}}, ~greater};
   end

   always_comb begin
      slot_in = slot_ff;
      if (commit && prev_greater) begin
         slot_in = prev_slot;
      end else if (commit && greater) begin
         slot_in.valid      = 1'b1;
         slot_in.node_id    = item.new_node_id;
         slot_in.distance   = item.new_distance;
         slot_in.back_node  = item.new_back_node;
         slot_in.explorable = item.new_explorable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= rst_slot;
         tok_ff  <= '0;
      end else begin
         slot_ff <= slot_in;
         tok_ff  <= tok_in_nxt;
      end
   end

   assign slot_out = slot_ff;
   assign tok_out  = tok_ff;

endmodule
